>>> rtl/core/dpfm_pkg.sv
// shared types and constants for the demand paging frame manager
package dpfm_pkg;

  localparam int unsigned FRAMES_DEF    = 64;
  localparam int unsigned PROCESSES_DEF = 4;
  localparam int unsigned PAGES_DEF     = 256;

  localparam logic [1:0] POL_LAST   = 2'd0;
  localparam logic [1:0] POL_RANDOM = 2'd1;
  localparam logic [1:0] POL_LRU    = 2'd2;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_FRAMES = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_SCAN_FREE,
    ST_PICK,
    ST_MOD,
    ST_SCAN_LRU,
    ST_OWNER,
    ST_STAMP,
    ST_EVICT,
    ST_COMMIT,
    ST_OUT
  } state_t;

endpackage

>>> rtl/core/dpfm_modulo.sv
// restoring bit-serial remainder of a 31-bit word by the active frame count
module dpfm_modulo #(
  parameter int unsigned CW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [30:0]   dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [CW-1:0] remainder
);

  logic [30:0]   shreg;
  logic [CW-1:0] rem;
  logic [4:0]    cnt;
  logic          busy;
  logic [CW:0]   trial;

  always_comb begin
    trial = {rem, shreg[30]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd30) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[29:0], 1'b0};
      if (trial >= {1'b0, divisor}) rem <= CW'(trial - {1'b0, divisor});
      else                          rem <= CW'(trial);
    end
  end

  assign remainder = rem;

endmodule

>>> rtl/core/demand_paging_frame_manager.sv
// top level: frame manager with page table, frame tables and fault sequencer
// a fault scans for a free frame and, if none is free, picks a victim by the random
// pick, the lru scan or the last frame; result stalls hold the item in the output state
// one item at a time, the next is taken in the cycle after the result leaves
// rst is synchronous; afterwards a clearing pass over every page table entry
// runs before the first item is taken
module demand_paging_frame_manager #(
  parameter int unsigned FRAMES            = dpfm_pkg::FRAMES_DEF,
  parameter int unsigned PROCESSES         = dpfm_pkg::PROCESSES_DEF,
  parameter int unsigned PAGES_PER_PROCESS = dpfm_pkg::PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  proc_id,
  input  logic [7:0]  page_number,
  input  logic [30:0] random_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        fault,
  output logic [5:0]  frame_index,
  output logic        evicted,
  output logic [1:0]  victim_process,
  output logic [7:0]  victim_page,
  output logic [31:0] residency
);

  localparam int unsigned TOTAL = PROCESSES * PAGES_PER_PROCESS;
  localparam int unsigned FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW    = $clog2(FRAMES + 1);
  localparam int unsigned SW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;

  // page table entry: resident flag plus frame, cleared by a sweep after reset
  logic [FW:0]    page_map [TOTAL];
  logic [31:0]    load_stamp [TOTAL];
  logic [SW-1:0]  frame_owner [FRAMES];
  logic [31:0]    frame_last_use [FRAMES];
  logic [FRAMES-1:0] frame_used;

  logic [1:0]     policy;
  logic [6:0]     frames_cfg;
  logic [31:0]    ref_count;
  logic [FW-1:0]  last_frame;

  dpfm_pkg::state_t state, state_next;

  logic [SW-1:0]  slot, clr_addr, pm_addr, ls_addr;
  logic [FW:0]    pm_rdata;
  logic [31:0]    ls_rdata, lu_rdata;
  logic [SW-1:0]  fo_rdata;
  logic [30:0]    rnd;
  logic [CW-1:0]  nact;
  logic [CW-1:0]  idx;
  logic [FW-1:0]  frame, best;
  logic [31:0]    best_age, age;
  logic           is_fault, is_evict, first;
  logic [SW-1:0]  owner;
  logic           mod_start, mod_done;
  logic [CW-1:0]  mod_rem;
  logic [FW-1:0]  lu_addr;

  // active frame count, clamped to 1..FRAMES
  always_comb begin
    if (frames_cfg == 7'd0) nact = CW'(1);
    else if (32'(frames_cfg) > FRAMES) nact = CW'(FRAMES);
    else nact = CW'(frames_cfg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= dpfm_pkg::POL_LAST;
      frames_cfg <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpfm_pkg::CFG_POLICY: policy     <= cfg_data[1:0];
        dpfm_pkg::CFG_FRAMES: frames_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  dpfm_modulo #(.CW(CW)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(rnd),
    .divisor(nact), .done(mod_done), .remainder(mod_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dpfm_pkg::ST_CLEAR:  if (clr_addr == SW'(TOTAL - 1)) state_next = dpfm_pkg::ST_IDLE;
      dpfm_pkg::ST_IDLE:   if (in_valid) state_next = dpfm_pkg::ST_LOOKUP;
      dpfm_pkg::ST_LOOKUP: state_next = dpfm_pkg::ST_DECIDE;
      dpfm_pkg::ST_DECIDE: begin
        if (pm_rdata[FW]) state_next = dpfm_pkg::ST_COMMIT;
        else state_next = dpfm_pkg::ST_SCAN_FREE;
      end
      dpfm_pkg::ST_SCAN_FREE: begin
        if (!frame_used[idx[FW-1:0]]) state_next = dpfm_pkg::ST_COMMIT;
        else if (idx == '0) state_next = dpfm_pkg::ST_PICK;
      end
      dpfm_pkg::ST_PICK: begin
        if (policy == dpfm_pkg::POL_LAST) state_next = dpfm_pkg::ST_OWNER;
        else if (policy == dpfm_pkg::POL_RANDOM) state_next = dpfm_pkg::ST_MOD;
        else state_next = dpfm_pkg::ST_SCAN_LRU;
      end
      dpfm_pkg::ST_MOD:      if (mod_done) state_next = dpfm_pkg::ST_OWNER;
      dpfm_pkg::ST_SCAN_LRU: if (idx == nact) state_next = dpfm_pkg::ST_OWNER;
      dpfm_pkg::ST_OWNER: begin
        if (frame_used[frame]) state_next = dpfm_pkg::ST_STAMP;
        else state_next = dpfm_pkg::ST_COMMIT;
      end
      dpfm_pkg::ST_STAMP:  state_next = dpfm_pkg::ST_EVICT;
      dpfm_pkg::ST_EVICT:  state_next = dpfm_pkg::ST_COMMIT;
      dpfm_pkg::ST_COMMIT: state_next = dpfm_pkg::ST_OUT;
      dpfm_pkg::ST_OUT:    if (!out_stall) state_next = dpfm_pkg::ST_IDLE;
      default:             state_next = dpfm_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = (state != dpfm_pkg::ST_IDLE);
    out_valid = (state == dpfm_pkg::ST_OUT);
    mod_start = (state == dpfm_pkg::ST_PICK) && (policy == dpfm_pkg::POL_RANDOM);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= dpfm_pkg::ST_CLEAR;
    else     state <= state_next;
  end

  // page table port: clearing sweep, lookup, eviction clear, load
  // victim owner is valid in the stamp state, its load stamp in the evict state that follows
  always_comb begin
    pm_addr = slot;
    if (state == dpfm_pkg::ST_EVICT) pm_addr = owner;
    ls_addr = (state == dpfm_pkg::ST_STAMP) ? fo_rdata : slot;
    age     = ref_count - lu_rdata;
    lu_addr = idx[FW-1:0];
  end

  always_ff @(posedge clk) begin
    if (state == dpfm_pkg::ST_CLEAR) page_map[clr_addr] <= '0;
    else if (state == dpfm_pkg::ST_EVICT) page_map[owner] <= '0;
    else if (state == dpfm_pkg::ST_COMMIT && is_fault) page_map[slot] <= {1'b1, frame};
    pm_rdata <= page_map[pm_addr];
  end

  always_ff @(posedge clk) begin
    if (state == dpfm_pkg::ST_COMMIT && is_fault) load_stamp[slot] <= ref_count;
    ls_rdata <= load_stamp[ls_addr];
  end

  always_ff @(posedge clk) begin
    if (state == dpfm_pkg::ST_COMMIT) frame_last_use[frame] <= ref_count;
    lu_rdata <= frame_last_use[lu_addr];
  end

  always_ff @(posedge clk) begin
    if (state == dpfm_pkg::ST_COMMIT && is_fault) frame_owner[frame] <= slot;
    fo_rdata <= frame_owner[frame];
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      frame_used <= '0;
      ref_count  <= '0;
      last_frame <= '0;
    end else begin
      if (state == dpfm_pkg::ST_CLEAR) clr_addr <= clr_addr + SW'(1);
      if (state == dpfm_pkg::ST_IDLE && in_valid) ref_count <= ref_count + 32'd1;
      if (state == dpfm_pkg::ST_COMMIT) begin
        last_frame <= frame;
        if (is_fault) frame_used[frame] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      dpfm_pkg::ST_IDLE: begin
        slot <= SW'((32'(proc_id) % PROCESSES) * PAGES_PER_PROCESS
                    + (32'(page_number) % PAGES_PER_PROCESS));
        rnd  <= random_value;
        is_evict <= 1'b0;
        victim_process <= '0;
        victim_page    <= '0;
        residency      <= '0;
      end
      dpfm_pkg::ST_DECIDE: begin
        is_fault <= !pm_rdata[FW];
        frame    <= pm_rdata[FW-1:0];
        idx      <= nact - CW'(1);
      end
      dpfm_pkg::ST_SCAN_FREE: begin
        frame <= idx[FW-1:0];
        if (idx != '0) idx <= idx - CW'(1);
      end
      dpfm_pkg::ST_PICK: begin
        frame <= last_frame;
        idx   <= '0;
        first <= 1'b1;
      end
      dpfm_pkg::ST_MOD: frame <= mod_rem[FW-1:0];
      dpfm_pkg::ST_SCAN_LRU: begin
        // read data is registered, so it belongs to the previous idx
        if (idx != '0) begin
          if (first || age > best_age) begin
            best     <= FW'(idx - CW'(1));
            best_age <= age;
          end
          first <= 1'b0;
        end
        if (idx == nact) frame <= (first || age > best_age) ? FW'(idx - CW'(1)) : best;
        else idx <= idx + CW'(1);
      end
      dpfm_pkg::ST_STAMP: begin
        owner    <= fo_rdata;
        is_evict <= 1'b1;
        victim_process <= 2'(fo_rdata / SW'(PAGES_PER_PROCESS));
        victim_page    <= 8'(fo_rdata % SW'(PAGES_PER_PROCESS));
      end
      dpfm_pkg::ST_EVICT: residency <= ref_count - ls_rdata;
      default: ;
    endcase
  end

  assign fault       = is_fault;
  assign frame_index = 6'(frame);
  assign evicted     = is_evict;

endmodule

>>> dv/tb.sv
// testbench for the demand paging frame manager: directed table, random phases, scoreboard
`timescale 1ns / 1ps

module tb;

  localparam int TOTAL_PAGES = 1024;
  localparam int NUM_FRAMES  = 64;
  localparam int IDLE_LIMIT  = 6000;   // covers the page table clearing pass
  localparam int RAND_ITEMS  = 1150;

  // one result item
  typedef struct packed {
    logic        fault;
    logic [5:0]  frame;
    logic        ev;
    logic [1:0]  vproc;
    logic [7:0]  vpage;
    logic [31:0] res;
  } outcome_t;

  // one row of the directed table: either a register write or a reference
  typedef struct {
    bit         is_cfg;
    logic       reg_idx;
    logic [6:0] reg_val;
    logic [1:0] proc;
    logic [7:0] page;
    logic [30:0] rnd;
    bit         typed;
    outcome_t   want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = dpfm_pkg::CFG_POLICY;
  logic [6:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  proc_id = '0;
  logic [7:0]  page_number = '0;
  logic [30:0] random_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic        fault;
  logic [5:0]  frame_index;
  logic        evicted;
  logic [1:0]  victim_process;
  logic [7:0]  victim_page;
  logic [31:0] residency;

  // shadow copy of the frame manager state
  logic [6:0]  pm_map   [TOTAL_PAGES];
  logic [31:0] pm_stamp [TOTAL_PAGES];
  bit          fr_used  [NUM_FRAMES];
  logic [9:0]  fr_owner [NUM_FRAMES];
  logic [31:0] fr_last  [NUM_FRAMES];
  logic [31:0] ref_count;
  logic [5:0]  last_touched;
  logic [1:0]  cur_policy;
  logic [6:0]  cur_frames;

  // policy and frame count of each random phase
  logic [1:0] ph_policy [12] = '{dpfm_pkg::POL_LAST, dpfm_pkg::POL_RANDOM, dpfm_pkg::POL_LRU,
                                 2'd3, dpfm_pkg::POL_RANDOM, dpfm_pkg::POL_LAST,
                                 dpfm_pkg::POL_LRU, dpfm_pkg::POL_RANDOM, dpfm_pkg::POL_LRU,
                                 dpfm_pkg::POL_LAST, dpfm_pkg::POL_LRU, dpfm_pkg::POL_RANDOM};
  logic [6:0] ph_frames [12] = '{7'd64, 7'd1, 7'd64, 7'd8, 7'd64, 7'd3, 7'd2, 7'd33,
                                 7'd16, 7'd0, 7'd127, 7'd17};

  outcome_t expected_results[$];
  row_t     directed[$];
  int       errors = 0;
  int       results_seen = 0;
  int       faults_seen = 0;
  int       evictions_seen = 0;
  int       refs_sent = 0;
  int       idle_cycles = 0;
  bit       quiet_send = 0;

  demand_paging_frame_manager uut (.*);

  always #6 clk = ~clk;

  // frame count after clamping the register value
  function automatic int active_frames();
    if (cur_frames == 0) return 1;
    if (cur_frames > NUM_FRAMES) return NUM_FRAMES;
    return int'(cur_frames);
  endfunction

  // page table / frame table update for one reference
  function automatic outcome_t resolve_reference(logic [1:0] proc, logic [7:0] page,
                                                 logic [30:0] rnd);
    outcome_t   o;
    int         slot;
    int         n;
    int         victim;
    int         owner;
    bit         found;
    logic [31:0] age;
    logic [31:0] best_age;
    o = '0;
    slot = int'(proc) * 256 + int'(page);
    found = 0;
    victim = 0;
    best_age = 0;
    ref_count = ref_count + 1;
    if (pm_map[slot] != 0) begin
      o.frame = 6'(pm_map[slot] - 1);
    end else begin
      o.fault = 1'b1;
      n = active_frames();
      for (int i = n - 1; i >= 0 && !found; i--) begin
        if (!fr_used[i]) begin
          victim = i;
          found = 1;
        end
      end
      if (!found) begin
        if (cur_policy == dpfm_pkg::POL_LAST) begin
          victim = int'(last_touched);
        end else if (cur_policy == dpfm_pkg::POL_RANDOM) begin
          victim = int'(rnd % n);
        end else begin
          // oldest last use wins, ties go to the lowest frame
          for (int i = 0; i < n; i++) begin
            age = ref_count - fr_last[i];
            if (i == 0 || age > best_age) begin
              victim = i;
              best_age = age;
            end
          end
        end
        if (fr_used[victim]) begin
          owner = int'(fr_owner[victim]);
          o.ev = 1'b1;
          o.vproc = 2'(owner / 256);
          o.vpage = 8'(owner % 256);
          o.res = ref_count - pm_stamp[owner];
          pm_map[owner] = '0;
        end
      end
      o.frame = 6'(victim);
      fr_used[victim] = 1;
      fr_owner[victim] = 10'(slot);
      pm_map[slot] = 7'(victim + 1);
      pm_stamp[slot] = ref_count;
    end
    last_touched = o.frame;
    fr_last[o.frame] = ref_count;
    return o;
  endfunction

  function automatic row_t ref_row(logic [1:0] p, logic [7:0] pg, logic [30:0] r,
                                   bit typed = 0, outcome_t w = '0);
    row_t t;
    t = '{default: '0};
    t.proc = p;
    t.page = pg;
    t.rnd = r;
    t.typed = typed;
    t.want = w;
    return t;
  endfunction

  function automatic row_t cfg_row(logic idx, logic [6:0] v);
    row_t t;
    t = '{default: '0};
    t.is_cfg = 1;
    t.reg_idx = idx;
    t.reg_val = v;
    return t;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("[%0t] %s: got %0h expected %0h", $time, what, got, want);
  endtask

  // one reference item through the valid/stall handshake
  task automatic send_reference(logic [1:0] p, logic [7:0] pg, logic [30:0] r,
                                bit typed, outcome_t w);
    outcome_t o;
    int g;
    in_valid <= 1'b1;
    proc_id <= p;
    page_number <= pg;
    random_value <= r;
    do @(posedge clk); while (in_stall);
    o = resolve_reference(p, pg, r);
    expected_results.push_back(typed ? w : o);
    refs_sent++;
    g = quiet_send ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // register write, only once every pending result has come back
  task automatic write_register(logic idx, logic [6:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == dpfm_pkg::CFG_POLICY) cur_policy = v[1:0];
    else cur_frames = v;
  endtask

  // result side: random stall with quiet stretches
  initial begin
    int hold;
    bit quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) quiet = ~quiet;
      hold = quiet ? 0 : pick_gap();
      out_stall <= (hold > 0);
      if (hold > 1) repeat (hold - 1) @(posedge clk);
    end
  end

  // scoreboard: compare each result item against the oldest expectation
  always @(posedge clk) begin
    outcome_t w;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (fault) faults_seen++;
      if (evicted) evictions_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(frame_index), 32'hffff_ffff);
      end else begin
        w = expected_results.pop_front();
        if (fault !== w.fault) report_mismatch("fault", 32'(fault), 32'(w.fault));
        if (frame_index !== w.frame)
          report_mismatch("frame_index", 32'(frame_index), 32'(w.frame));
        if (evicted !== w.ev) report_mismatch("evicted", 32'(evicted), 32'(w.ev));
        if (victim_process !== w.vproc)
          report_mismatch("victim_process", 32'(victim_process), 32'(w.vproc));
        if (victim_page !== w.vpage)
          report_mismatch("victim_page", 32'(victim_page), 32'(w.vpage));
        if (residency !== w.res) report_mismatch("residency", residency, w.res);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int per_phase;
    int w;
    logic [1:0] p;
    logic [7:0] pg;
    logic [30:0] r;
    row_t t;

    foreach (pm_map[i]) begin
      pm_map[i] = '0;
      pm_stamp[i] = '0;
    end
    foreach (fr_used[i]) begin
      fr_used[i] = 0;
      fr_owner[i] = '0;
      fr_last[i] = '0;
    end
    ref_count = '0;
    last_touched = '0;
    cur_policy = dpfm_pkg::POL_LAST;
    cur_frames = 7'd64;

    // after reset: highest free frames fill first, then a hit
    directed.push_back(ref_row(2'd0, 8'd0, 31'd0, 1, '{1'b1, 6'd63, 1'b0, 2'd0, 8'd0, 32'd0}));
    directed.push_back(ref_row(2'd3, 8'd255, 31'h7fff_ffff, 1,
                               '{1'b1, 6'd62, 1'b0, 2'd0, 8'd0, 32'd0}));
    directed.push_back(ref_row(2'd0, 8'd0, 31'd0, 1, '{1'b0, 6'd63, 1'b0, 2'd0, 8'd0, 32'd0}));
    // frame count of zero acts as one frame
    directed.push_back(cfg_row(dpfm_pkg::CFG_FRAMES, 7'd0));
    directed.push_back(ref_row(2'd1, 8'd17, 31'd0, 1, '{1'b1, 6'd0, 1'b0, 2'd0, 8'd0, 32'd0}));
    // last referenced frame is the victim
    directed.push_back(ref_row(2'd2, 8'd5, 31'd0, 1, '{1'b1, 6'd0, 1'b1, 2'd1, 8'd17, 32'd1}));
    // page in a frame above the shrunk count still hits
    directed.push_back(ref_row(2'd0, 8'd0, 31'd0, 1, '{1'b0, 6'd63, 1'b0, 2'd0, 8'd0, 32'd0}));
    directed.push_back(cfg_row(dpfm_pkg::CFG_POLICY, 7'(dpfm_pkg::POL_RANDOM)));
    directed.push_back(cfg_row(dpfm_pkg::CFG_FRAMES, 7'd2));
    directed.push_back(ref_row(2'd1, 8'd1, 31'd0, 1, '{1'b1, 6'd1, 1'b0, 2'd0, 8'd0, 32'd0}));
    directed.push_back(ref_row(2'd1, 8'd2, 31'd5, 1, '{1'b1, 6'd1, 1'b1, 2'd1, 8'd1, 32'd1}));
    // lru takes the older of the two frames
    directed.push_back(cfg_row(dpfm_pkg::CFG_POLICY, 7'(dpfm_pkg::POL_LRU)));
    directed.push_back(ref_row(2'd3, 8'd3, 31'd0, 1, '{1'b1, 6'd0, 1'b1, 2'd2, 8'd5, 32'd4}));
    // policy 3 and an oversized frame count
    directed.push_back(cfg_row(dpfm_pkg::CFG_POLICY, 7'd3));
    directed.push_back(cfg_row(dpfm_pkg::CFG_FRAMES, 7'd127));
    directed.push_back(ref_row(2'd2, 8'd200, 31'd0));
    directed.push_back(ref_row(2'd1, 8'h55, 31'h2aaa_aaaa));
    directed.push_back(ref_row(2'd2, 8'haa, 31'h5555_5555));
    directed.push_back(ref_row(2'd3, 8'd3, 31'h7fff_ffff));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      t = directed[i];
      if (t.is_cfg) write_register(t.reg_idx, t.reg_val);
      else send_reference(t.proc, t.page, t.rnd, t.typed, t.want);
    end

    // random phases, each with its own policy and frame count
    per_phase = RAND_ITEMS / 12;
    for (int ph = 0; ph < 12; ph++) begin
      write_register(dpfm_pkg::CFG_POLICY, 7'(ph_policy[ph]));
      write_register(dpfm_pkg::CFG_FRAMES, ph_frames[ph]);
      quiet_send = ($urandom_range(0, 3) == 0);
      w = active_frames() / 2 + 4;   // working set a bit larger than the frames
      for (int k = 0; k < per_phase; k++) begin
        p = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 15) pg = 8'($urandom_range(0, 255));
        else pg = 8'($urandom_range(0, w - 1));
        case ($urandom_range(0, 9))
          0: r = '0;
          1: r = 31'h7fff_ffff;
          default: r = 31'($urandom);
        endcase
        send_reference(p, pg, r, 0, '0);
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("sent %0d references across 12 settings of policy and frame count", refs_sent);
    $display("results %0d, faults %0d, evictions %0d, mismatches %0d",
             results_seen, faults_seen, evictions_seen, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
